@@ src/assert_macros.svh @@
// Assertion macros used by the classifier core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle, outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// Checks that a condition implies a consequence in the next cycle, outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

@@ src/lspc_pkg.sv @@
// Types and constants for the line sensor position classifier.
package lspc_pkg;

	// Field widths.
	localparam int SENSOR_W = 8;
	localparam int COUNT_W  = 4;
	localparam int OFFSET_W = 4;
	localparam int RUN_W    = 4;

	// Reset value of the long run threshold.
	localparam logic [RUN_W-1:0] MAX_RUN_RESET = 4'd6;

	// Snapshot patterns that are handled before the run search.
	localparam logic [SENSOR_W-1:0] ALL_WHITE = 8'hFF;
	localparam logic [SENSOR_W-1:0] ALL_BLACK = 8'h00;

	// Classification codes. Codes 6 and 7 are not used and never arise.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_LOST_L    = 3'd1,
		ST_LOST_R    = 3'd2,
		ST_LOST_U    = 3'd3,
		ST_ALL_BLACK = 3'd4,
		ST_BROKEN    = 3'd5
	} track_status_t;

	// Direction of the last good line position.
	typedef enum logic [1:0] {
		DIR_NONE  = 2'd0,
		DIR_LEFT  = 2'd1,
		DIR_RIGHT = 2'd2
	} dir_t;

endpackage

@@ src/line_sensor_position_classifier_core.sv @@
// Line sensor position classifier: one snapshot in, one classification out.
//
// Usage:
// - Input channel (in_valid, in_ready, sensor_bits) carries one 8-bit sensor
//   snapshot per item; a 0 bit means that sensor sees black.
// - Output channel (out_valid, out_ready) carries one result item per input
//   item: raw_echo, black_total, line_offset and track_status.
// - cfg_wr_en writes cfg_wr_data into the long run threshold at once; write it
//   only while no item is in flight.
// - An accepted item waits in an input register that feeds the classification
//   logic, which loads the result register; out_valid rises as the item
//   enters the result register.
// - Throughput is one item per cycle while out_ready is high, limited only by the result register.
// - When out_ready is low the result register holds its item, the input
//   register fills, and in_ready then drops until the result is taken.
// - The kept position and direction update as an ok item enters the result
//   register, so the next item always sees the state its predecessor left.
// - Reset empties both registers, sets the threshold to 6 and clears the kept
//   position and direction.
`include "assert_macros.svh"

module line_sensor_position_classifier_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [lspc_pkg::SENSOR_W-1:0]    sensor_bits,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [lspc_pkg::SENSOR_W-1:0]    raw_echo,
	output logic [lspc_pkg::COUNT_W-1:0]     black_total,
	output logic signed [lspc_pkg::OFFSET_W-1:0] line_offset,
	output logic [2:0]                       track_status,
	input  logic                             cfg_wr_en,
	input  logic [lspc_pkg::RUN_W-1:0]       cfg_wr_data
);
	import lspc_pkg::*;

	logic                        valid_s1;
	logic [SENSOR_W-1:0]         raw_s1;
	logic                        valid_s2;
	logic [SENSOR_W-1:0]         raw_s2;
	logic [COUNT_W-1:0]          count_s2;
	logic signed [OFFSET_W-1:0]  offset_s2;
	track_status_t               status_s2;

	logic [RUN_W-1:0]            max_run_q;
	logic signed [OFFSET_W-1:0]  kept_offset_q;
	dir_t                        kept_dir_q;

	logic                        advance;
	logic                        load_s1;
	logic                        move_s1;

	logic [COUNT_W-1:0]          count;
	logic [2:0]                  first;
	logic [2:0]                  last;
	logic                        found;
	logic [COUNT_W-1:0]          span;
	logic signed [4:0]           pos;
	logic [COUNT_W-1:0]          res_count;
	logic signed [OFFSET_W-1:0]  res_offset;
	track_status_t               res_status;
	logic                        res_ok;

	// Pipeline control: the pipe moves when the result register is free or taken.
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign load_s1  = in_valid && in_ready;
	assign move_s1  = valid_s1 && advance;

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_run_q <= MAX_RUN_RESET;
		end else if (cfg_wr_en) begin
			max_run_q <= cfg_wr_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			raw_s1 <= sensor_bits;
		end
	end

	// Count the black sensors and find the first and last black one.
	always_comb begin
		count = '0;
		first = '0;
		last  = '0;
		found = 1'b0;
		for (int i = 0; i < SENSOR_W; i++) begin
			if (!raw_s1[i]) begin
				if (!found) begin
					first = 3'(i);
				end
				found = 1'b1;
				last  = 3'(i);
				count = count + 4'd1;
			end
		end
		span = {1'b0, last} - {1'b0, first} + 4'd1;
		pos  = $signed({2'b00, first}) + $signed({2'b00, last}) - 5'sd7;
	end

	// Classify the snapshot.
	always_comb begin
		res_count  = count;
		res_offset = '0;
		res_status = ST_OK;
		res_ok     = 1'b0;
		if (raw_s1 == ALL_WHITE) begin
			res_offset = kept_offset_q;
			case (kept_dir_q)
				DIR_LEFT:  res_status = ST_LOST_L;
				DIR_RIGHT: res_status = ST_LOST_R;
				default:   res_status = ST_LOST_U;
			endcase
		end else if (raw_s1 == ALL_BLACK) begin
			res_status = ST_ALL_BLACK;
		end else if (span != count) begin
			res_status = ST_BROKEN;
		end else if (count >= max_run_q) begin
			res_status = ST_ALL_BLACK;
		end else begin
			res_offset = pos[OFFSET_W-1:0];
			res_ok     = 1'b1;
		end
	end

	// Kept position follows every ok item; the direction follows it when the offset is not zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_offset_q <= '0;
			kept_dir_q    <= DIR_NONE;
		end else if (move_s1 && res_ok) begin
			kept_offset_q <= res_offset;
			if (pos < 0) begin
				kept_dir_q <= DIR_LEFT;
			end else if (pos > 0) begin
				kept_dir_q <= DIR_RIGHT;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			raw_s2    <= raw_s1;
			count_s2  <= res_count;
			offset_s2 <= res_offset;
			status_s2 <= res_status;
		end
	end

	assign out_valid    = valid_s2;
	assign raw_echo     = raw_s2;
	assign black_total  = count_s2;
	assign line_offset  = offset_s2;
	assign track_status = status_s2;

	// Checks on the design's own logic.
	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, load_s1, valid_s1, "accepted item lost")
	`ASSERT_IMPLIES(a_no_dir_zero_offset, clk, arst_n, kept_dir_q == DIR_NONE, kept_offset_q == 4'sd0, "kept offset set without direction")
	`ASSERT_IMPLIES(a_ok_short_run, clk, arst_n, valid_s2 && status_s2 == ST_OK, count_s2 != 4'd0 && count_s2 < max_run_q, "ok result with bad run length")
	`ASSERT_IMPLIES(a_white_is_lost, clk, arst_n, valid_s2 && raw_s2 == ALL_WHITE, status_s2 == ST_LOST_L || status_s2 == ST_LOST_R || status_s2 == ST_LOST_U, "all white item not reported lost")

endmodule
